@@ hw/rtl/flba_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flba_pkg
// shared constants and types for the free list block allocator
// ----------------------------------------------------------------------------
package flba_pkg;

    // pool geometry
    localparam int POOL_BLOCKS = 256;
    localparam int IDX_W       = $clog2(POOL_BLOCKS);
    localparam int LINK_W      = IDX_W + 1;

    // field widths
    localparam int COUNT_W = 9;
    localparam int CHUNK_W = 11;
    localparam int ADDR_W  = 18;
    localparam int CMD_W   = 2;
    localparam int BI_W    = 8;
    localparam int ACT_W   = (LINK_W > COUNT_W) ? LINK_W : COUNT_W;

    // stream widths
    localparam int S_TDATA_W = ((ADDR_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((BI_W + ADDR_W + 7) / 8) * 8;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHUNK_WORDS = 1'd1;

    // reset values of the registers
    localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST = COUNT_W'(256);
    localparam logic [CHUNK_W-1:0] CHUNK_WORDS_RST = CHUNK_W'(32);

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_INIT  = 2'd2
    } t_cmd;

    // divider handshake
    typedef struct packed {
        logic                start;
        logic [ADDR_W-1:0]   dividend;
        logic [CHUNK_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [ADDR_W-1:0]   quotient;
    } t_div_rsp;

endpackage

@@ hw/rtl/flba_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flba_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module flba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/flba_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flba_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module flba_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  flba_pkg::t_div_req i_req,
    output flba_pkg::t_div_rsp o_rsp
);
    import flba_pkg::*;

    localparam int CNT_W = $clog2(ADDR_W);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [CHUNK_W-1:0] r_rem;
    logic [CHUNK_W-1:0] r_div;
    logic [ADDR_W-1:0]  r_quo;

    logic [CHUNK_W:0]   rem_sh;
    logic               ge;

    assign rem_sh = {r_rem, r_quo[ADDR_W-1]};
    assign ge     = rem_sh >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(ADDR_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[ADDR_W-2:0], ge};
            r_rem <= ge ? CHUNK_W'(rem_sh - {1'b0, r_div}) : rem_sh[CHUNK_W-1:0];
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

@@ hw/rtl/free_list_block_allocator_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_list_block_allocator_core
// fixed-size block pool with a lifo free list kept in a link ram
// ----------------------------------------------------------------------------
// One request is handled at a time and gives exactly one response. Allocate
// pops the head block and returns its index and word address (index times
// chunk_words); the result passes from the registered read of the link ram
// in S_ALLOC_RD through S_RESULT into the output register. Free divides the
// word address by chunk_words in a bit-serial divider, one quotient bit per
// cycle over 18 divide steps, then pushes the block if it lies below the
// active count and answers through S_RESULT. An empty pool, a zero chunk
// size on free and an unknown command go straight to S_RESULT and answer
// not ok. Reinitialize rewrites the link ram one entry per cycle below the
// active count and then answers ok. After reset the same pass fills all 256
// link entries with index plus one; o_s_axis_tready stays low until it ends.
// A new request is taken as soon as the previous one has reached the output
// register, even while that response still waits for i_m_axis_tready.
// Configuration writes are taken at any time but belong in idle periods only.
// ----------------------------------------------------------------------------
module free_list_block_allocator_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [flba_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [flba_pkg::CHUNK_W-1:0]      i_cfg_wdata,
    // request stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [flba_pkg::S_TDATA_W-1:0]    i_s_axis_tdata,  // free_address, zero pad
    input  logic [flba_pkg::CMD_W-1:0]        i_s_axis_tuser,  // command
    // response stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [flba_pkg::M_TDATA_W-1:0]    o_m_axis_tdata,  // block_index, block_address, pad
    output logic                              o_m_axis_tuser   // ok
);
    import flba_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC_RD,
        S_DIV,
        S_CLEAR,
        S_RESULT
    } t_state;

    t_state             r_state;

    // configuration registers
    logic [COUNT_W-1:0] r_block_count;
    logic [CHUNK_W-1:0] r_chunk_words;

    // free list state
    logic [LINK_W-1:0]  r_head;

    // chain rebuild pass
    logic [LINK_W-1:0]  r_clr_idx;
    logic [ACT_W-1:0]   r_clr_end;
    logic               r_clr_rsp;   // pass belongs to a reinitialize request

    // pending response
    logic               r_res_ok;
    logic [BI_W-1:0]    r_res_idx;
    logic [ADDR_W-1:0]  r_res_addr;
    logic [IDX_W-1:0]   r_idx;

    // output register
    logic               r_m_valid;
    logic               r_m_ok;
    logic [BI_W-1:0]    r_m_idx;
    logic [ADDR_W-1:0]  r_m_addr;

    // active count, block_count limited to the pool size
    logic [ACT_W-1:0]   act_count;
    logic               accept;
    logic               out_free;
    logic [ADDR_W-1:0]  req_addr;
    logic               head_ok;
    logic               quo_ok;
    logic               clr_done;
    logic [LINK_W-1:0]  ram_rdata;
    logic [ADDR_W-1:0]  prod;
    logic               push_we;
    logic               clr_we;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [LINK_W-1:0]  ram_wdata;
    t_div_req           div_req;
    t_div_rsp           div_rsp;

    assign act_count = (ACT_W'(r_block_count) > ACT_W'(POOL_BLOCKS))
                     ? ACT_W'(POOL_BLOCKS) : ACT_W'(r_block_count);

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_m_valid || i_m_axis_tready;
    assign req_addr        = i_s_axis_tdata[ADDR_W-1:0];

    // empty test and range test against the active count
    assign head_ok = ADDR_W'(r_head) < ADDR_W'(act_count);
    assign quo_ok  = div_rsp.quotient < ADDR_W'(act_count);

    // word address of the popped block, truncated to the field width
    assign prod = ADDR_W'(r_idx) * ADDR_W'(r_chunk_words);

    // link ram writes: push on a successful free, or one entry of the rebuild pass
    assign clr_done  = (ACT_W'(r_clr_idx) == r_clr_end);
    assign push_we   = (r_state == S_DIV) && div_rsp.done && quo_ok;
    assign clr_we    = (r_state == S_CLEAR) && !clr_done;
    assign ram_we    = push_we || clr_we;
    assign ram_waddr = clr_we ? r_clr_idx[IDX_W-1:0] : div_rsp.quotient[IDX_W-1:0];
    assign ram_wdata = clr_we ? (r_clr_idx + LINK_W'(1)) : r_head;

    assign div_req.start    = accept && (t_cmd'(i_s_axis_tuser) == CMD_FREE)
                            && (r_chunk_words != '0);
    assign div_req.dividend = req_addr;
    assign div_req.divisor  = r_chunk_words;

    flba_ram #(
        .WIDTH (LINK_W),
        .DEPTH (POOL_BLOCKS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_head[IDX_W-1:0]),   // head read runs ahead for allocate
        .o_rdata (ram_rdata)
    );

    flba_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // fill every link entry with index plus one before taking requests
            r_state       <= S_CLEAR;
            r_block_count <= BLOCK_COUNT_RST;
            r_chunk_words <= CHUNK_WORDS_RST;
            r_head        <= '0;
            r_clr_idx     <= '0;
            r_clr_end     <= ACT_W'(POOL_BLOCKS);
            r_clr_rsp     <= 1'b0;
            r_m_valid     <= 1'b0;
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_BLOCK_COUNT: r_block_count <= i_cfg_wdata[COUNT_W-1:0];
                    REG_CHUNK_WORDS: r_chunk_words <= i_cfg_wdata;
                    default: ;
                endcase
            end

            // handshake drains the output unless a new response loads it
            if (r_m_valid && i_m_axis_tready && (r_state != S_RESULT)) begin
                r_m_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_res_ok   <= (t_cmd'(i_s_axis_tuser) == CMD_INIT);
                        r_res_idx  <= '0;
                        r_res_addr <= '0;
                        r_idx      <= r_head[IDX_W-1:0];
                        case (t_cmd'(i_s_axis_tuser))
                            CMD_ALLOC: begin
                                r_state <= head_ok ? S_ALLOC_RD : S_RESULT;
                            end
                            CMD_FREE: begin
                                r_state <= (r_chunk_words != '0) ? S_DIV : S_RESULT;
                            end
                            CMD_INIT: begin
                                // entries below the active count go back to index plus one
                                r_head    <= '0;
                                r_clr_idx <= '0;
                                r_clr_end <= act_count;
                                r_clr_rsp <= 1'b1;
                                r_state   <= S_CLEAR;
                            end
                            default: r_state <= S_RESULT;
                        endcase
                    end
                end
                S_ALLOC_RD: begin
                    // pop the head
                    r_head     <= ram_rdata;
                    r_res_ok   <= 1'b1;
                    r_res_idx  <= BI_W'(r_idx);
                    r_res_addr <= prod;
                    r_state    <= S_RESULT;
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        if (quo_ok) begin
                            // push the freed block, ram write happens alongside
                            r_head    <= LINK_W'(div_rsp.quotient);
                            r_res_ok  <= 1'b1;
                            r_res_idx <= BI_W'(div_rsp.quotient);
                        end
                        r_state <= S_RESULT;
                    end
                end
                S_CLEAR: begin
                    // one link entry per cycle, ram write happens alongside
                    if (clr_done) begin
                        r_state <= r_clr_rsp ? S_RESULT : S_IDLE;
                    end else begin
                        r_clr_idx <= r_clr_idx + LINK_W'(1);
                    end
                end
                S_RESULT: begin
                    if (out_free) begin
                        r_m_valid <= 1'b1;
                        r_m_ok    <= r_res_ok;
                        r_m_idx   <= r_res_idx;
                        r_m_addr  <= r_res_addr;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tuser  = r_m_ok;
    assign o_m_axis_tdata  = M_TDATA_W'({r_m_addr, r_m_idx});

endmodule

@@ tb/tb_free_list_block_allocator_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_free_list_block_allocator_core
// self-checking bench for the free list block allocator
// ----------------------------------------------------------------------------
// Requests (allocate, free, reinitialize) go in on the slave stream and one
// response per request comes back on the master stream. A scoreboard class
// keeps its own copy of the free chain and the two registers, works out the
// response for each accepted request and compares the responses in order.
// The run walks through several pool settings, the extremes among them, with
// random gaps on both streams, one long back-pressure hold and a stretch
// without gaps.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic                          ok;
    logic [flba_pkg::BI_W-1:0]     blk_idx;
    logic [flba_pkg::ADDR_W-1:0]   blk_addr;
} t_pool_rsp;

class pool_scoreboard;
    logic [flba_pkg::LINK_W-1:0]   head;
    logic [flba_pkg::LINK_W-1:0]   links [flba_pkg::POOL_BLOCKS];
    logic [flba_pkg::COUNT_W-1:0]  block_count;
    logic [flba_pkg::CHUNK_W-1:0]  chunk_words;
    t_pool_rsp                     expected_q[$];
    int                            errors;

    function new();
        block_count = flba_pkg::BLOCK_COUNT_RST;
        chunk_words = flba_pkg::CHUNK_WORDS_RST;
        for (int i = 0; i < flba_pkg::POOL_BLOCKS; i++)
            links[i] = flba_pkg::LINK_W'(i + 1);
        head   = '0;
        errors = 0;
    endfunction

    function void write_reg(logic [flba_pkg::CFG_IDX_W-1:0] idx,
                            logic [flba_pkg::CHUNK_W-1:0] data);
        if (idx == flba_pkg::REG_BLOCK_COUNT)
            block_count = data[flba_pkg::COUNT_W-1:0];
        else
            chunk_words = data;
    endfunction

    function int unsigned active_count();
        return (block_count > flba_pkg::POOL_BLOCKS) ? flba_pkg::POOL_BLOCKS
                                                     : int'(block_count);
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // update the chain for one accepted request and queue its response
    function t_pool_rsp note_request(flba_pkg::t_cmd cmd,
                                     logic [flba_pkg::ADDR_W-1:0] faddr);
        t_pool_rsp   r;
        int unsigned n;
        int unsigned k;
        r = '0;
        n = active_count();
        case (cmd)
            flba_pkg::CMD_ALLOC: begin
                if (head < n) begin
                    r.ok       = 1'b1;
                    r.blk_idx  = head[flba_pkg::BI_W-1:0];
                    r.blk_addr = flba_pkg::ADDR_W'(int'(head) * int'(chunk_words));
                    head       = links[head];
                end
            end
            flba_pkg::CMD_FREE: begin
                if (chunk_words != 0) begin
                    k = int'(faddr) / int'(chunk_words);
                    if (k < n) begin
                        links[k]  = head;
                        head      = flba_pkg::LINK_W'(k);
                        r.ok      = 1'b1;
                        r.blk_idx = flba_pkg::BI_W'(k);
                    end
                end
            end
            flba_pkg::CMD_INIT: begin
                for (int i = 0; i < n; i++)
                    links[i] = flba_pkg::LINK_W'(i + 1);
                head = '0;
                r.ok = 1'b1;
            end
            default: ;
        endcase
        expected_q.push_back(r);
        return r;
    endfunction

    function void check_response(t_pool_rsp got);
        t_pool_rsp exp;
        if (expected_q.size() == 0) begin
            $display("%0t: response with no request waiting: ok %0b idx %0d addr %0d",
                     $realtime, got.ok, got.blk_idx, got.blk_addr);
            errors++;
            return;
        end
        exp = expected_q.pop_front();
        if (got.ok !== exp.ok) begin
            $display("%0t: ok expected %0b actual %0b", $realtime, exp.ok, got.ok);
            errors++;
        end
        if (got.blk_idx !== exp.blk_idx) begin
            $display("%0t: block_index expected %0d actual %0d",
                     $realtime, exp.blk_idx, got.blk_idx);
            errors++;
        end
        if (got.blk_addr !== exp.blk_addr) begin
            $display("%0t: block_address expected %0d actual %0d",
                     $realtime, exp.blk_addr, got.blk_addr);
            errors++;
        end
    endfunction
endclass

module tb_free_list_block_allocator_core;
    import flba_pkg::*;

    localparam int ITEMS_PER_PHASE = 135;
    localparam int NUM_PHASES      = 7;
    localparam int STEADY_FROM     = 300;   // no gaps on either side in this window
    localparam int STEADY_TO       = 500;
    localparam int HOLD_AT         = 700;   // request count that starts the long stall
    localparam int HOLD_CYCLES     = 400;
    localparam int SETTLE_CYCLES   = 30;    // longer than a whole free request
    localparam int STALL_LIMIT     = 3000;  // cycles with no handshake at all

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CHUNK_W-1:0]      cfg_wdata = '0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata = '0;      // free_address, zero pad
    logic [CMD_W-1:0]        s_tuser = '0;      // command
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_TDATA_W-1:0]    m_tdata;           // block_index, block_address, pad
    logic                    m_tuser;           // ok

    pool_scoreboard          sb;
    int                      sent = 0;
    bit                      steady = 1'b0;
    bit                      hold_req = 1'b0;
    logic [BI_W-1:0]         live_blocks[$];   // blocks the bench believes are allocated

    free_list_block_allocator_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // drive one request and wait for its handshake; entered just after a
    // rising edge, so tvalid may still be high from the previous request
    task automatic send_request(input t_cmd cmd, input logic [ADDR_W-1:0] faddr);
        int        gap;
        t_pool_rsp r;
        steady = (sent >= STEADY_FROM) && (sent < STEADY_TO);
        if (sent == HOLD_AT)
            hold_req = 1'b1;
        @(negedge i_clk);
        if (!steady && $urandom_range(0, 99) < 13) begin
            gap = $urandom_range(1, 8);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(faddr);
        s_tuser  <= cmd;
        do @(posedge i_clk); while (!s_tready);
        r = sb.note_request(cmd, faddr);
        sent++;
        // keep the allocated list in step so frees can target real blocks
        if (cmd == CMD_INIT) begin
            live_blocks.delete();
        end else if (r.ok && cmd == CMD_ALLOC) begin
            live_blocks.push_back(r.blk_idx);
        end else if (r.ok && cmd == CMD_FREE) begin
            foreach (live_blocks[j]) begin
                if (live_blocks[j] == r.blk_idx) begin
                    live_blocks.delete(j);
                    break;
                end
            end
        end
    endtask

    // drop tvalid and let every response drain before touching registers
    task automatic drain_responses();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CHUNK_W-1:0] data);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        sb.write_reg(idx, data);
        @(negedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // mostly alloc/free traffic on real blocks, with some stray frees,
    // alloc bursts that can run the pool dry and the odd reinitialize
    task automatic random_request();
        int unsigned pick;
        int unsigned span;
        int unsigned j;
        int unsigned chunk;
        chunk = int'(sb.chunk_words);
        span  = sb.active_count() * chunk;
        if (span > (1 << ADDR_W))
            span = 1 << ADDR_W;
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            repeat ($urandom_range(4, 20)) send_request(CMD_ALLOC, ADDR_W'($urandom));
        end else if (pick < 42 || (pick < 80 && live_blocks.size() == 0)) begin
            send_request(CMD_ALLOC, ADDR_W'($urandom));
        end else if (pick < 80) begin
            j = $urandom_range(0, live_blocks.size() - 1);
            send_request(CMD_FREE, ADDR_W'(int'(live_blocks[j]) * chunk
                                           + $urandom_range(0, chunk - 1)));
        end else if (pick < 88) begin
            // inside the pool, may be a double free
            send_request(CMD_FREE, ADDR_W'($urandom_range(0, span - 1)));
        end else if (pick < 95) begin
            send_request(CMD_FREE, ADDR_W'($urandom));
        end else begin
            send_request(CMD_INIT, ADDR_W'($urandom));
        end
    endtask

    // receiver: random stalls, plus one long hold counted here
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
                m_tready <= 1'b1;
            end else if (steady) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= 13);
            end
        end
    end

    // response checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready)
            sb.check_response({m_tuser, m_tdata[BI_W-1:0], m_tdata[BI_W +: ADDR_W]});
    end

    // watchdog on handshake activity
    initial begin : watchdog
        int stale;
        stale = 0;
        while (stale < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stale = 0;
            else
                stale++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        int phase_count [NUM_PHASES];
        int phase_chunk [NUM_PHASES];
        int target;
        // zero means pick at random: a small pool, or any chunk size from 1 to 1024
        phase_count = '{256, 1, 256, 0, 1, 256, 0};
        phase_chunk = '{32,  1, 1024, 0, 1024, 1, 0};
        sb = new();

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset setting: pop, free aligned and unaligned, double free,
        // free far beyond the pool
        send_request(CMD_ALLOC, '0);
        send_request(CMD_ALLOC, '1);
        send_request(CMD_FREE, ADDR_W'(0));
        send_request(CMD_FREE, ADDR_W'(33));
        send_request(CMD_FREE, ADDR_W'(33));
        send_request(CMD_FREE, '1);
        send_request(CMD_ALLOC, '0);
        send_request(CMD_INIT, '0);
        drain_responses();

        // one block of one word: empty pool and out-of-range free
        write_reg(REG_BLOCK_COUNT, CHUNK_W'(1));
        write_reg(REG_CHUNK_WORDS, CHUNK_W'(1));
        send_request(CMD_ALLOC, '0);
        send_request(CMD_ALLOC, '0);
        send_request(CMD_FREE, ADDR_W'(1));
        send_request(CMD_FREE, ADDR_W'(0));
        send_request(CMD_INIT, '1);
        drain_responses();

        // largest pool and stride: top address frees the last block
        write_reg(REG_BLOCK_COUNT, CHUNK_W'(256));
        write_reg(REG_CHUNK_WORDS, CHUNK_W'(1024));
        send_request(CMD_FREE, '1);
        send_request(CMD_ALLOC, '0);
        send_request(CMD_ALLOC, '0);
        send_request(CMD_INIT, '0);
        drain_responses();

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_reg(REG_BLOCK_COUNT, (phase_count[p] != 0) ? CHUNK_W'(phase_count[p])
                                                             : CHUNK_W'($urandom_range(2, 24)));
            write_reg(REG_CHUNK_WORDS, (phase_chunk[p] != 0) ? CHUNK_W'(phase_chunk[p])
                                                             : CHUNK_W'($urandom_range(1, 1024)));
            // leave the old chain in place half the time
            if ($urandom_range(0, 1) == 1)
                send_request(CMD_INIT, '0);
            target = sent + ITEMS_PER_PHASE;
            while (sent < target)
                random_request();
            drain_responses();
        end

        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/flba_pkg.sv
hw/rtl/flba_ram.sv
hw/rtl/flba_div.sv
hw/rtl/free_list_block_allocator_core.sv
tb/tb_free_list_block_allocator_core.sv
